// ===== src/cnfs_pkg.sv =====
// Package with the shared types, codes and helper functions of the slot allocator.
`timescale 1ns / 1ps

package cnfs_pkg;

	localparam int SLOT_W = 11;
	localparam int STAT_W = 2;
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	localparam logic [STAT_W-1:0] STATUS_GRANTED = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_BAD     = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SCAN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic set_bad;
		logic rd;
		logic advance;
		logic grant;
		logic set_full;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic hit;
		logic last_visit;
	} stat_t;

	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				pos = BIT_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ===== src/cnfs_req_if.sv =====
// Request channel interface that carries the wanted slot.
`timescale 1ns / 1ps

interface cnfs_req_if;
	logic                          valid;
	logic                          ready;
	logic [cnfs_pkg::SLOT_W-1:0]   wanted_slot;

	modport source (output valid, output wanted_slot, input ready);
	modport sink (input valid, input wanted_slot, output ready);
endinterface

// ===== src/cnfs_rsp_if.sv =====
// Response channel interface that carries the granted slot and the status.
`timescale 1ns / 1ps

interface cnfs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cnfs_pkg::SLOT_W-1:0]   granted_slot;
	logic [cnfs_pkg::STAT_W-1:0]   status;

	modport source (output valid, output granted_slot, output status, input ready);
	modport sink (input valid, input granted_slot, input status, output ready);
endinterface

// ===== src/cnfs_cfg_if.sv =====
// Configuration write channel interface that carries the slot count.
`timescale 1ns / 1ps

interface cnfs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cnfs_pkg::SLOT_W-1:0]   slot_count;

	modport source (output valid, output slot_count, input ready);
	modport sink (input valid, input slot_count, output ready);
endinterface

// ===== src/cnfs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cnfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/cnfs_ctrl.sv =====
// Controller state machine that sequences clearing, word scans and response beats.
`timescale 1ns / 1ps

module cnfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  cnfs_pkg::stat_t  stat,
	output cnfs_pkg::cmd_t   cmd
);

	cnfs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnfs_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cnfs_pkg::S_CLEAR: begin
				if (stat.clr_last) begin
					state_d = cnfs_pkg::S_IDLE;
				end
			end
			cnfs_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = stat.bad ? cnfs_pkg::S_OUT : cnfs_pkg::S_READ;
				end
			end
			cnfs_pkg::S_READ: begin
				state_d = cnfs_pkg::S_SCAN;
			end
			cnfs_pkg::S_SCAN: begin
				if (stat.hit || stat.last_visit) begin
					state_d = cnfs_pkg::S_OUT;
				end
			end
			cnfs_pkg::S_OUT: begin
				if (rsp_ready) begin
					state_d = cnfs_pkg::S_IDLE;
				end
			end
			default: state_d = cnfs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			cnfs_pkg::S_CLEAR: begin
				cmd.clr = 1'b1;
			end
			cnfs_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load    = 1'b1;
					cmd.set_bad = stat.bad;
				end
			end
			cnfs_pkg::S_READ: begin
				cmd.rd = 1'b1;
			end
			cnfs_pkg::S_SCAN: begin
				if (stat.hit) begin
					cmd.grant = 1'b1;
				end else if (stat.last_visit) begin
					cmd.set_full = 1'b1;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			cnfs_pkg::S_OUT: begin
				rsp_valid = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== src/cnfs_dp.sv =====
// Datapath with the slot count register, the scan pointers, the occupancy RAM and the result.
`timescale 1ns / 1ps

module cnfs_dp #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cnfs_pkg::SLOT_W-1:0]   cfg_slot_count,
	input  logic [cnfs_pkg::SLOT_W-1:0]   wanted_slot,
	input  cnfs_pkg::cmd_t                cmd,
	output cnfs_pkg::stat_t               stat,
	output logic [cnfs_pkg::SLOT_W-1:0]   granted_slot,
	output logic [cnfs_pkg::STAT_W-1:0]   status
);

	localparam int WORDS  = (MAX_SLOTS + cnfs_pkg::WORD_W - 1) / cnfs_pkg::WORD_W;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SW     = cnfs_pkg::SLOT_W;
	localparam int WW     = cnfs_pkg::WORD_W;
	localparam int BW     = cnfs_pkg::BIT_W;

	logic [SW-1:0]     slot_count_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] w_q, w0_q, wl_q, w_next;
	logic [BW-1:0]     b0_q, lb_q, pos;
	logic              first_q;
	logic [SW-1:0]     granted_q;
	logic [cnfs_pkg::STAT_W-1:0] status_q;

	logic [SW-1:0]     count;
	logic [SW-1:0]     want_idx, last_idx;
	logic [WW-1:0]     rd_data, lo_mask, hi_mask, free_bits;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WW-1:0]     ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SW'(MAX_SLOTS);
			clr_q        <= '0;
		end else begin
			if (cfg_we) begin
				slot_count_q <= cfg_slot_count;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		count    = (32'(slot_count_q) > 32'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : slot_count_q;
		want_idx = wanted_slot - 1'b1;
		last_idx = count - 1'b1;
		w_next   = (w_q == wl_q) ? '0 : w_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w0_q    <= ADDR_W'(want_idx >> BW);
			w_q     <= ADDR_W'(want_idx >> BW);
			b0_q    <= want_idx[BW-1:0];
			wl_q    <= ADDR_W'(last_idx >> BW);
			lb_q    <= last_idx[BW-1:0];
			first_q <= 1'b1;
		end else if (cmd.advance) begin
			w_q     <= w_next;
			first_q <= 1'b0;
		end
		if (cmd.set_bad) begin
			granted_q <= '0;
			status_q  <= cnfs_pkg::STATUS_BAD;
		end else if (cmd.set_full) begin
			granted_q <= '0;
			status_q  <= cnfs_pkg::STATUS_FULL;
		end else if (cmd.grant) begin
			granted_q <= SW'({w_q, pos}) + 1'b1;
			status_q  <= cnfs_pkg::STATUS_GRANTED;
		end
	end

	always_comb begin
		if (first_q) begin
			lo_mask = {WW{1'b1}} << b0_q;
		end else if (w_q == w0_q) begin
			lo_mask = ~({WW{1'b1}} << b0_q);
		end else begin
			lo_mask = {WW{1'b1}};
		end
		hi_mask   = (w_q == wl_q) ? ({WW{1'b1}} >> (BW'(WW - 1) - lb_q)) : {WW{1'b1}};
		free_bits = ~rd_data & lo_mask & hi_mask;
		pos       = cnfs_pkg::lowest_set(free_bits);
	end

	always_comb begin
		stat.clr_last   = (clr_q == ADDR_W'(WORDS - 1));
		stat.bad        = (wanted_slot == '0) || (wanted_slot > count);
		stat.hit        = |free_bits;
		stat.last_visit = !first_q && (w_q == w0_q);
	end

	always_comb begin
		ram_we    = cmd.clr || cmd.grant;
		ram_waddr = cmd.clr ? clr_q : w_q;
		ram_wdata = cmd.clr ? '0 : (rd_data | (WW'(1) << pos));
		ram_re    = cmd.rd || cmd.advance;
		ram_raddr = cmd.advance ? w_next : w_q;
	end

	cnfs_ram #(
		.WIDTH (WW),
		.DEPTH (WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (rd_data)
	);

	assign granted_slot = granted_q;
	assign status       = status_q;

endmodule

// ===== src/circular_next_free_slot_allocator.sv =====
// Top level of the circular next-free slot allocator.
`timescale 1ns / 1ps

// Usage:
// A request beat on req carries wanted_slot, numbered from one to the slot count.
// Every request gives exactly one response beat on rsp with granted_slot and status:
// granted, all slots taken, or wanted slot out of range. A granted slot stays taken
// until reset. The cfg channel writes the slot count and is always ready; write it
// only while no request is in flight.
// The occupancy map lives in a RAM of 32-bit words and is scanned one word per cycle,
// starting at the word of the wanted slot and wrapping from the last slot to slot one.
// An in-range request goes from accept through a read state and a scan state, where
// it visits from one up to the word count plus one words (33 at the default size),
// to the response. An out-of-range request answers in the cycle after accept.
// Only one request is handled at a time; req is ready again in the cycle after the
// response beat is taken, so a stalled rsp holds the response and blocks new requests.
// After reset the RAM is cleared one word per cycle, MAX_SLOTS / 32 rounded up words,
// 32 at the default size, and no request is accepted during that pass.

module circular_next_free_slot_allocator #(
	parameter int MAX_SLOTS = 1024
) (
	input logic         clk,
	input logic         arst_n,
	cnfs_req_if.sink    req,
	cnfs_rsp_if.source  rsp,
	cnfs_cfg_if.sink    cfg
);

	cnfs_pkg::cmd_t  cmd;
	cnfs_pkg::stat_t stat;

	assign cfg.ready = 1'b1;

	cnfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cnfs_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg.valid),
		.cfg_slot_count (cfg.slot_count),
		.wanted_slot    (req.wanted_slot),
		.cmd            (cmd),
		.stat           (stat),
		.granted_slot   (rsp.granted_slot),
		.status         (rsp.status)
	);

endmodule

// ===== test/tb_circular_next_free_slot_allocator.sv =====
// Self-checking testbench that drives slot requests and checks every grant against a predictor.
`timescale 1ns / 1ps

module tb_circular_next_free_slot_allocator;

	localparam int SLOT_W = cnfs_pkg::SLOT_W;
	localparam int STAT_W = cnfs_pkg::STAT_W;
	localparam int MAX_SLOTS = 1024;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 150;
	localparam logic [SLOT_W-1:0] SLOT_ALL_ONES = '1;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [STAT_W-1:0] status;
	} grant_t;

	class grant_ledger;
		bit taken[1:MAX_SLOTS];
		logic [SLOT_W-1:0] count_reg;
		grant_t due[$];
		int fails;

		function new();
			count_reg = SLOT_W'(MAX_SLOTS);
			fails = 0;
			foreach (taken[i]) taken[i] = 1'b0;
		endfunction

		function void set_count(input logic [SLOT_W-1:0] value);
			count_reg = value;
		endfunction

		function int unsigned active_count();
			return (count_reg > MAX_SLOTS) ? MAX_SLOTS : count_reg;
		endfunction

		function void note_request(input logic [SLOT_W-1:0] wanted);
			int unsigned lim;
			int unsigned s;
			grant_t g;
			lim = active_count();
			g.slot = '0;
			g.status = cnfs_pkg::STATUS_BAD;
			if (wanted != 0 && wanted <= lim) begin
				g.status = cnfs_pkg::STATUS_FULL;
				s = wanted;
				for (int k = 0; k < lim; k++) begin
					if (!taken[s]) begin
						taken[s] = 1'b1;
						g.slot = SLOT_W'(s);
						g.status = cnfs_pkg::STATUS_GRANTED;
						break;
					end
					s = (s == lim) ? 1 : s + 1;
				end
			end
			due.insert(due.size(), g);
		endfunction

		function void check_grant(input logic [SLOT_W-1:0] slot,
				input logic [STAT_W-1:0] status);
			grant_t g;
			if (due.size() == 0) begin
				$display("%0t: response beat with nothing expected, slot %0d status %0d",
					$time, slot, status);
				fails++;
				return;
			end
			g = due.pop_front();
			if (slot !== g.slot) begin
				$display("%0t: granted_slot mismatch, expected %0d actual %0d",
					$time, g.slot, slot);
				fails++;
			end
			if (status !== g.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, g.status, status);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_pending;
	grant_ledger ledger;

	cnfs_req_if req_ch ();
	cnfs_rsp_if rsp_ch ();
	cnfs_cfg_if cfg_ch ();

	circular_next_free_slot_allocator #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20000000;
		$display("FAIL circular_next_free_slot_allocator");
		$finish;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			ledger.check_grant(rsp_ch.granted_slot, rsp_ch.status);
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 76;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 76;
			end
			default: begin
				send_idle_pct = 22;
				recv_stall_pct = 22;
			end
		endcase
	endtask

	task automatic send_request(input logic [SLOT_W-1:0] wanted);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.wanted_slot <= wanted;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		ledger.note_request(wanted);
	endtask

	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		while (ledger.due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_slot_count(input logic [SLOT_W-1:0] value);
		drain_responses();
		cfg_ch.valid <= 1'b1;
		cfg_ch.slot_count <= value;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		ledger.set_count(value);
	endtask

	task automatic random_phase(input logic [SLOT_W-1:0] count, input int mode,
			input bit squeeze);
		int unsigned lim;
		int r;
		set_slot_count(count);
		set_idling(mode);
		lim = ledger.active_count();
		if (squeeze) hold_pending = 1'b1;
		repeat (PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 5) send_request('0);
			else if (r < 15) send_request(SLOT_W'($urandom_range(lim + 1, 2047)));
			else send_request(SLOT_W'($urandom_range(1, lim)));
		end
	endtask

	initial begin
		ledger = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_pending = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.wanted_slot = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.slot_count = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(3);
		send_request('0);
		send_request(SLOT_ALL_ONES);
		send_request(11'd1025);
		send_request(11'd1024);
		send_request(11'd1024);
		send_request(11'd1);
		send_request(11'd31);
		send_request(11'd32);
		send_request(11'd33);
		send_request(11'd32);
		send_request(11'd1023);
		send_request(11'd1023);

		set_slot_count(11'd1);
		send_request(11'd1);
		send_request(11'd2);
		send_request('0);

		set_slot_count('0);
		send_request(11'd1);
		send_request('0);

		set_slot_count(SLOT_ALL_ONES);
		send_request(11'd1024);
		send_request(11'd1025);
		send_request(SLOT_ALL_ONES);

		set_slot_count(11'd3);
		send_request(11'd3);
		send_request(11'd4);

		set_slot_count(11'd35);
		send_request(11'd33);

		random_phase(11'd16, 0, 1'b0);
		random_phase(11'd64, 1, 1'b0);
		random_phase(11'd5, 2, 1'b0);
		random_phase(11'd200, 3, 1'b1);
		random_phase(11'd1024, 0, 1'b0);
		random_phase(11'd500, 1, 1'b0);
		random_phase(SLOT_ALL_ONES, 2, 1'b0);
		random_phase(11'd1, 3, 1'b0);

		drain_responses();
		if (ledger.fails == 0) begin
			$display("PASS circular_next_free_slot_allocator");
		end else begin
			$display("FAIL circular_next_free_slot_allocator");
		end
		$finish;
	end

endmodule
